// ----- rtl/spq_pkg.sv -----
`default_nettype none
package spq_pkg;
   localparam int DEPTH        = 16;
   localparam int ID_WIDTH     = 16;
   localparam int PRIO_WIDTH   = 8;
   localparam int PTR_WIDTH    = $clog2(DEPTH);
   localparam int CNT_WIDTH    = $clog2(DEPTH + 1);
   localparam int FUNC_WIDTH   = 2;
   localparam int STATUS_WIDTH = 2;

   typedef logic [PTR_WIDTH-1:0]    ptr_type;
   typedef logic [CNT_WIDTH-1:0]    cnt_type;
   typedef logic [ID_WIDTH-1:0]     id_type;
   typedef logic [PRIO_WIDTH-1:0]   prio_type;
   typedef logic [FUNC_WIDTH-1:0]   func_type;
   typedef logic [STATUS_WIDTH-1:0] status_type;

   localparam func_type FUNC_APPEND = 2'd0;
   localparam func_type FUNC_INSERT = 2'd1;
   localparam func_type FUNC_REMOVE = 2'd2;

   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_EMPTY = 2'd1;
   localparam status_type STATUS_FULL  = 2'd2;

   localparam cnt_type FULL_COUNT = CNT_WIDTH'(DEPTH);

   typedef struct packed {
      id_type   id;
      prio_type prio;
   } entry_type;

   typedef struct packed {
      logic      wr_en;
      ptr_type   wr_addr;
      entry_type wr_data;
      ptr_type   rd_addr;
   } mem_req_type;

   // Physical slot of a logical position in the circular store.
   function automatic ptr_type slot_addr(ptr_type base, ptr_type offset);
      logic [PTR_WIDTH:0] sum;
      sum = {1'b0, base} + {1'b0, offset};
      if (sum >= (PTR_WIDTH + 1)'(DEPTH)) begin
         sum = sum - (PTR_WIDTH + 1)'(DEPTH);
      end
      return sum[PTR_WIDTH-1:0];
   endfunction

   function automatic ptr_type ptr_dec(ptr_type p);
      ptr_type r;
      if (p == '0) begin
         r = PTR_WIDTH'(DEPTH - 1);
      end else begin
         r = p - 1'b1;
      end
      return r;
   endfunction
endpackage
`default_nettype wire

// ----- rtl/spq_if.sv -----
`default_nettype none
interface spq_req_if;
   import spq_pkg::*;
   logic     valid;
   logic     ready;
   func_type func;
   id_type   item_id;
   prio_type item_priority;

   modport source (output valid, func, item_id, item_priority, input ready);
   modport sink   (input valid, func, item_id, item_priority, output ready);
endinterface

interface spq_rsp_if;
   import spq_pkg::*;
   logic       valid;
   logic       ready;
   status_type status;
   id_type     removed_id;
   prio_type   removed_priority;
   cnt_type    entry_count;

   modport source (output valid, status, removed_id, removed_priority, entry_count,
                   input ready);
   modport sink   (input valid, status, removed_id, removed_priority, entry_count,
                   output ready);
endinterface
`default_nettype wire

// ----- rtl/spq_store.sv -----
`default_nettype none
module spq_store (
   input  logic                clock,
   input  spq_pkg::mem_req_type mem_req,
   output spq_pkg::entry_type   rd_data
);
   import spq_pkg::*;

   entry_type slot_mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         slot_mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      rd_data_ff <= slot_mem[mem_req.rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ----- rtl/spq_ctrl.sv -----
`default_nettype none
module spq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   spq_req_if.sink              req,
   spq_rsp_if.source            rsp,
   output spq_pkg::mem_req_type mem_req,
   input  spq_pkg::entry_type   rd_data
);
   import spq_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP,
      ST_HEAD,
      ST_TAIL,
      ST_WALK,
      ST_DONE
   } state_type;

   state_type  state_ff, state_in;
   ptr_type    head_ff, head_in;
   cnt_type    count_ff, count_in;
   ptr_type    idx_ff, idx_in;
   id_type     id_ff, id_in;
   prio_type   prio_ff, prio_in;
   status_type status_ff, status_in;
   id_type     rid_ff, rid_in;
   prio_type   rprio_ff, rprio_in;
   logic       rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff, rsp_status_in;
   id_type     rsp_id_ff, rsp_id_in;
   prio_type   rsp_prio_ff, rsp_prio_in;
   cnt_type    rsp_count_ff, rsp_count_in;

   logic      prio_above;
   entry_type item_entry;
   ptr_type   count_ptr;

   // Single shared compare: new item ranks above the entry just read.
   assign prio_above = prio_ff > rd_data.prio;
   assign item_entry = '{id: id_ff, prio: prio_ff};
   assign count_ptr  = count_ff[PTR_WIDTH-1:0];

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      id_in         = id_ff;
      prio_in       = prio_ff;
      status_in     = status_ff;
      rid_in        = rid_ff;
      rprio_in      = rprio_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_count_in  = rsp_count_ff;
      mem_req       = '{wr_en: 1'b0, wr_addr: head_ff, wr_data: item_entry,
                        rd_addr: head_ff};

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               id_in     = req.item_id;
               prio_in   = req.item_priority;
               status_in = STATUS_OK;
               rid_in    = '0;
               rprio_in  = '0;
               state_in  = ST_DONE;
               case (req.func)
                  FUNC_APPEND, FUNC_INSERT: begin
                     if (count_ff == FULL_COUNT) begin
                        status_in = STATUS_FULL;
                     end else if (req.func == FUNC_APPEND || count_ff == '0) begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = slot_addr(head_ff, count_ptr);
                        mem_req.wr_data = '{id: req.item_id, prio: req.item_priority};
                        count_in        = count_ff + 1'b1;
                     end else begin
                        state_in = ST_HEAD;
                     end
                  end
                  FUNC_REMOVE: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        state_in = ST_POP;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_POP: begin
            rid_in   = rd_data.id;
            rprio_in = rd_data.prio;
            head_in  = slot_addr(head_ff, PTR_WIDTH'(1));
            count_in = count_ff - 1'b1;
            state_in = ST_DONE;
         end
         ST_HEAD: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = ptr_dec(head_ff);
            if (prio_above) begin
               head_in  = ptr_dec(head_ff);
               count_in = count_ff + 1'b1;
               state_in = ST_DONE;
            end else begin
               // Copy the head into the free slot ahead of it in case the walk
               // moves the front part one place toward the head.
               mem_req.wr_data = rd_data;
               mem_req.rd_addr = slot_addr(head_ff, count_ptr - 1'b1);
               state_in        = ST_TAIL;
            end
         end
         ST_TAIL: begin
            if (!prio_above) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = slot_addr(head_ff, count_ptr);
               count_in        = count_ff + 1'b1;
               state_in        = ST_DONE;
            end else begin
               mem_req.rd_addr = slot_addr(head_ff, PTR_WIDTH'(1));
               idx_in          = PTR_WIDTH'(1);
               state_in        = ST_WALK;
            end
         end
         ST_WALK: begin
            // Entries ahead of the insert point move one slot toward the head.
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = slot_addr(ptr_dec(head_ff), idx_ff);
            if (prio_above) begin
               head_in  = ptr_dec(head_ff);
               count_in = count_ff + 1'b1;
               state_in = ST_DONE;
            end else begin
               mem_req.wr_data = rd_data;
               mem_req.rd_addr = slot_addr(head_ff, idx_ff + 1'b1);
               idx_in          = idx_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_id_in     = rid_ff;
               rsp_prio_in   = rprio_ff;
               rsp_count_in  = count_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         idx_ff        <= idx_in;
         id_ff         <= id_in;
         prio_ff       <= prio_in;
         status_ff     <= status_in;
         rid_ff        <= rid_in;
         rprio_ff      <= rprio_in;
         rsp_status_ff <= rsp_status_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_prio_ff   <= rsp_prio_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   assign req.ready            = (state_ff == ST_IDLE);
   assign rsp.valid            = rsp_valid_ff;
   assign rsp.status           = rsp_status_ff;
   assign rsp.removed_id       = rsp_id_ff;
   assign rsp.removed_priority = rsp_prio_ff;
   assign rsp.entry_count      = rsp_count_ff;
endmodule
`default_nettype wire

// ----- rtl/stable_priority_queue_unit.sv -----
// Bounded queue of up to 16 entries (id, priority) kept in service order.
// Input channel req_ch carries func (append, insert by priority, remove
// head), item_id and item_priority; output channel rsp_ch returns one item
// per request: status, removed id and priority, and the entry count after it.
// Entries live in a circular single-port-write, registered-read store; a
// small sequencer walks it with one shared priority comparator.
// Steps per item, from accept to the result:
//   append, insert into an empty queue, no-op, full or empty request: none
//   remove: one store read of the head
//   priority insert: a compare with the head, then with the tail, else a
//   walk toward the tail, with one store read per walked entry.
// The result is registered once the work ends and the result slot is free. The block takes no new
// item while it works on one. A stalled rsp_ch holds its item, and the block
// still accepts and works one more item, then waits until the slot frees.
// Synchronous reset empties the queue and drops any pending result.
`default_nettype none
module stable_priority_queue_unit (
   input logic        clock,
   input logic        reset,
   spq_req_if.sink    req_ch,
   spq_rsp_if.source  rsp_ch
);
   import spq_pkg::*;

   mem_req_type mem_req;
   entry_type   rd_data;

   spq_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   spq_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );
endmodule
`default_nettype wire

// ----- rtl/spq_checker.sv -----
`default_nettype none
module spq_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input spq_pkg::status_type rsp_status,
   input spq_pkg::id_type     rsp_removed_id,
   input spq_pkg::prio_type   rsp_removed_priority,
   input spq_pkg::cnt_type    rsp_entry_count
);
   import spq_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_removed_id) && $stable(rsp_entry_count))
      else $error("result item changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready stayed high after an accepted item");

   a_removed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_removed_id == '0
         && rsp_removed_priority == '0)
      else $error("failed request carries removed fields");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |-> rsp_entry_count == FULL_COUNT)
      else $error("full status with queue not full");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_EMPTY |-> rsp_entry_count == '0)
      else $error("empty status with entries stored");
endmodule

bind stable_priority_queue_unit spq_checker u_spq_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_ch.valid),
   .req_ready            (req_ch.ready),
   .rsp_valid            (rsp_ch.valid),
   .rsp_ready            (rsp_ch.ready),
   .rsp_status           (rsp_ch.status),
   .rsp_removed_id       (rsp_ch.removed_id),
   .rsp_removed_priority (rsp_ch.removed_priority),
   .rsp_entry_count      (rsp_ch.entry_count)
);
`default_nettype wire
